// ----- design/ipgw_pkg.sv -----
// shared types and constants of the ip-in-ip tunnel gateway mapper
`default_nettype none

package ipgw_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned STRIP_W = 6;
  localparam int unsigned SUM_W   = 19;

  localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
  localparam logic [7:0]  OUTER_TTL    = 8'd250;
  localparam logic [7:0]  OUTER_PROTO  = 8'd4;
  localparam logic [15:0] OUTER_HDR_LEN = 16'd20;

  typedef enum logic [1:0] {
    ACT_DECAP = 2'd0,
    ACT_ENCAP = 2'd1,
    ACT_DROP  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LEARN,
    ST_CSUM,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_en;
    logic learn_wr;
    logic csum_en;
    logic load_res;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind;
    logic scan_done;
    logic scan_hit;
    logic res_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/ipgw_req_if.sv -----
// request channel: one packet descriptor per request
`default_nettype none

interface ipgw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ipgw_pkg::ADDR_W-1:0]   outer_source;
  logic [ipgw_pkg::ADDR_W-1:0]   inner_source;
  logic [ipgw_pkg::ADDR_W-1:0]   destination;
  logic [ipgw_pkg::STRIP_W-1:0]  outer_header_bytes;
  logic [ipgw_pkg::LEN_W-1:0]    packet_length;

  modport source (
    output valid, kind, outer_source, inner_source, destination,
           outer_header_bytes, packet_length,
    input  ready
  );

  modport sink (
    input  valid, kind, outer_source, inner_source, destination,
           outer_header_bytes, packet_length,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/ipgw_res_if.sv -----
// result channel: one forwarding decision per request
`default_nettype none

interface ipgw_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [ipgw_pkg::STRIP_W-1:0]  strip_bytes;
  logic [ipgw_pkg::ADDR_W-1:0]   outer_destination;
  logic [ipgw_pkg::LEN_W-1:0]    total_length;
  logic [15:0]                   identification;
  logic [15:0]                   header_checksum;

  modport source (
    output valid, action, strip_bytes, outer_destination, total_length,
           identification, header_checksum,
    input  ready
  );

  modport sink (
    input  valid, action, strip_bytes, outer_destination, total_length,
           identification, header_checksum,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/ipgw_ctrl.sv -----
// controller state machine of the tunnel gateway mapper
`default_nettype none

module ipgw_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    req_valid_i,
  output logic                   req_ready_o,
  input  ipgw_pkg::dp_status_t   status_i,
  output ipgw_pkg::dp_cmd_t      cmd_o
);
  import ipgw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          if (!status_i.kind)         state_d = ST_LEARN;
          else if (status_i.scan_hit) state_d = ST_CSUM;
          else                        state_d = ST_DONE;
        end
      end
      ST_LEARN: state_d = ST_DONE;
      ST_CSUM:  state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.res_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      ST_SCAN:  cmd_o.scan_en  = 1'b1;
      ST_LEARN: cmd_o.learn_wr = 1'b1;
      ST_CSUM:  cmd_o.csum_en  = 1'b1;
      ST_DONE:  cmd_o.load_res = status_i.res_free;
      default: begin
        cmd_o       = '0;
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/ipgw_dp.sv -----
// datapath: gateway table memories, table walk, header checksum, result register
`default_nettype none

module ipgw_dp #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  ipgw_pkg::dp_cmd_t                cmd_i,
  output ipgw_pkg::dp_status_t             status_o,
  input  wire                              cfg_we_i,
  input  wire [ipgw_pkg::ADDR_W-1:0]       cfg_wdata_i,
  input  wire                              kind_i,
  input  wire [ipgw_pkg::ADDR_W-1:0]       outer_source_i,
  input  wire [ipgw_pkg::ADDR_W-1:0]       inner_source_i,
  input  wire [ipgw_pkg::ADDR_W-1:0]       destination_i,
  input  wire [ipgw_pkg::STRIP_W-1:0]      outer_header_bytes_i,
  input  wire [ipgw_pkg::LEN_W-1:0]        packet_length_i,
  output logic                             res_valid_o,
  input  wire                              res_ready_i,
  output logic [1:0]                       action_o,
  output logic [ipgw_pkg::STRIP_W-1:0]     strip_bytes_o,
  output logic [ipgw_pkg::ADDR_W-1:0]      outer_destination_o,
  output logic [ipgw_pkg::LEN_W-1:0]       total_length_o,
  output logic [15:0]                      identification_o,
  output logic [15:0]                      header_checksum_o
);
  import ipgw_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // table memories
  logic [ADDR_W-1:0] key_mem [TABLE_ENTRIES];
  logic [ADDR_W-1:0] gw_mem  [TABLE_ENTRIES];

  // captured request
  logic                kind_q;
  logic [ADDR_W-1:0]   key_q;
  logic [ADDR_W-1:0]   gw_in_q;
  logic [STRIP_W-1:0]  strip_q;
  logic [LEN_W-1:0]    plen_q;

  // config and persistent state
  logic [ADDR_W-1:0]   tsa_q;
  logic [15:0]         ident_q, ident_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [IDX_W-1:0]    rp_q, rp_d;

  // table walk
  logic [FILL_W-1:0]   issue_q, issue_d;
  logic                rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [ADDR_W-1:0]   key_rd_q;
  logic [ADDR_W-1:0]   gw_rd_q;
  logic                hit_q, hit_d;
  logic [IDX_W-1:0]    hit_idx_q;
  logic [ADDR_W-1:0]   hit_gw_q;
  logic                rd_issue;
  logic                match;

  // checksum
  logic [SUM_W-1:0]    sum_q;
  logic [LEN_W-1:0]    tot_len;
  logic [16:0]         fold1;
  logic [15:0]         fold2;

  // result register
  logic                res_valid_q, res_valid_d;

  logic [IDX_W-1:0]    slot;

  assign rd_issue = cmd_i.scan_en && !hit_q && (issue_q < fill_q);
  assign match    = rd_valid_q && (key_rd_q == key_q);

  assign status_o.kind      = kind_q;
  assign status_o.scan_hit  = hit_q;
  assign status_o.scan_done = hit_q || (!(issue_q < fill_q) && !rd_valid_q);
  assign status_o.res_free  = !res_valid_q || res_ready_i;

  // entries fill from index zero and are never dropped, so the fill count marks validity
  always_comb begin
    if (hit_q)                 slot = hit_idx_q;
    else if (fill_q < FILL_MAX) slot = fill_q[IDX_W-1:0];
    else                       slot = rp_q;
  end

  always_comb begin
    issue_d    = issue_q;
    rd_valid_d = 1'b0;
    hit_d      = hit_q;
    fill_d     = fill_q;
    rp_d       = rp_q;
    ident_d    = ident_q;
    if (cmd_i.capture) begin
      issue_d = '0;
      hit_d   = 1'b0;
    end else if (cmd_i.scan_en) begin
      if (rd_issue) begin
        issue_d    = issue_q + FILL_W'(1);
        rd_valid_d = 1'b1;
      end
      if (match) hit_d = 1'b1;
    end
    if (cmd_i.learn_wr && !hit_q) begin
      if (fill_q < FILL_MAX) begin
        fill_d = fill_q + FILL_W'(1);
      end else begin
        rp_d = (rp_q == IDX_LAST) ? '0 : rp_q + IDX_W'(1);
      end
    end
    if (cmd_i.load_res && kind_q && hit_q) ident_d = ident_q + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsa_q       <= '0;
      ident_q     <= '0;
      fill_q      <= '0;
      rp_q        <= '0;
      issue_q     <= '0;
      rd_valid_q  <= 1'b0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) tsa_q <= cfg_wdata_i;
      ident_q     <= ident_d;
      fill_q      <= fill_d;
      rp_q        <= rp_d;
      issue_q     <= issue_d;
      rd_valid_q  <= rd_valid_d;
      hit_q       <= hit_d;
      res_valid_q <= res_valid_d;
    end
  end

  // request capture and hit record
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      key_q   <= kind_i ? destination_i : inner_source_i;
      gw_in_q <= outer_source_i;
      strip_q <= outer_header_bytes_i;
      plen_q  <= packet_length_i;
    end
    if (cmd_i.scan_en && match && !hit_q) begin
      hit_idx_q <= rd_idx_q;
      hit_gw_q  <= gw_rd_q;
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.learn_wr) begin
      key_mem[slot] <= key_q;
      gw_mem[slot]  <= gw_in_q;
    end
    if (rd_issue) begin
      key_rd_q <= key_mem[issue_q[IDX_W-1:0]];
      gw_rd_q  <= gw_mem[issue_q[IDX_W-1:0]];
      rd_idx_q <= issue_q[IDX_W-1:0];
    end
  end

  // header sum over the ten 16-bit words, zero words left out
  assign tot_len = plen_q + OUTER_HDR_LEN;

  always_ff @(posedge clk_i) begin
    if (cmd_i.csum_en) begin
      sum_q <= SUM_W'(VER_IHL_TOS) + SUM_W'(tot_len) + SUM_W'(ident_q)
             + SUM_W'({OUTER_TTL, OUTER_PROTO})
             + SUM_W'(tsa_q[31:16]) + SUM_W'(tsa_q[15:0])
             + SUM_W'(hit_gw_q[31:16]) + SUM_W'(hit_gw_q[15:0]);
    end
  end

  // end-around carry, two folds are enough for a 19-bit sum
  assign fold1 = {1'b0, sum_q[15:0]} + 17'(sum_q[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_i.load_res)   res_valid_d = 1'b1;
    else if (res_ready_i) res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      action_o            <= ACT_DROP;
      strip_bytes_o       <= '0;
      outer_destination_o <= '0;
      total_length_o      <= '0;
      identification_o    <= '0;
      header_checksum_o   <= '0;
      if (!kind_q) begin
        action_o      <= ACT_DECAP;
        strip_bytes_o <= strip_q;
      end else if (hit_q) begin
        action_o            <= ACT_ENCAP;
        outer_destination_o <= hit_gw_q;
        total_length_o      <= tot_len;
        identification_o    <= ident_q;
        header_checksum_o   <= ~fold2;
      end
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

`default_nettype wire

// ----- design/ipip_tunnel_gateway_mapper.sv -----
// top level of the ip-in-ip tunnel gateway mapper
//
//   channel   dir   handshake          carries
//   req_i     in    valid / ready      packet descriptor (kind, addresses, lengths)
//   res_o     out   valid / ready      action, strip length, outer header fields
//   cfg       in    cfg_we_i only      tunnel source address
//
// one request goes through accept, the table walk (one read issued per cycle
// through the key memory read port, then the compare of the last read, ending
// after the first match), a learn write (kind 0) or checksum step (kind 1 hit),
// then the load into the result register; a kind 1 miss skips the middle step.
// reset clears the fill count, replace pointer, id counter and tunnel source; no
// clearing pass. a result still waiting on res_o holds the load, and the next request
// is taken only after the load.
`default_nettype none

module ipip_tunnel_gateway_mapper #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [ipgw_pkg::ADDR_W-1:0]  cfg_wdata_i,
  ipgw_req_if.sink                    req_i,
  ipgw_res_if.source                  res_o
);
  import ipgw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       req_ready;

  // controller only sequences; all state of the table lives in the datapath
  ipgw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  // table memories, walk, checksum and the result register
  ipgw_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .kind_i               (req_i.kind),
    .outer_source_i       (req_i.outer_source),
    .inner_source_i       (req_i.inner_source),
    .destination_i        (req_i.destination),
    .outer_header_bytes_i (req_i.outer_header_bytes),
    .packet_length_i      (req_i.packet_length),
    .res_valid_o          (res_o.valid),
    .res_ready_i          (res_o.ready),
    .action_o             (res_o.action),
    .strip_bytes_o        (res_o.strip_bytes),
    .outer_destination_o  (res_o.outer_destination),
    .total_length_o       (res_o.total_length),
    .identification_o     (res_o.identification),
    .header_checksum_o    (res_o.header_checksum)
  );

endmodule

`default_nettype wire

// ----- sim/ipgw_tb_pkg.sv -----
// packet kind codes shared by the mapper testbench and its checker
package ipgw_tb_pkg;

  typedef enum logic {
    PKT_TUNNELLED = 1'b0,
    PKT_PLAIN     = 1'b1
  } pkt_kind_e;

endpackage

// ----- sim/ipgw_route_checker.sv -----
// route checker: mirrors the gateway table and compares every mapper decision
module ipgw_route_checker #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  ipgw_req_if               req,
  ipgw_res_if               res,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import ipgw_pkg::*;
  import ipgw_tb_pkg::*;

  typedef struct packed {
    action_e     act;
    logic [5:0]  strip;
    logic [31:0] gateway;
    logic [15:0] total_len;
    logic [15:0] ident;
    logic [15:0] csum;
  } decision_t;

  logic [31:0] route_key  [TABLE_ENTRIES];
  logic [31:0] route_gw   [TABLE_ENTRIES];
  logic        route_live [TABLE_ENTRIES];
  int          victim;
  logic [15:0] next_ident;
  logic [31:0] tunnel_src;
  decision_t   expected_decisions[$];
  int unsigned errors;

  function automatic int find_route(input logic [31:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (route_live[i] && route_key[i] == key) return i;
    end
    return -1;
  endfunction

  // existing key in place, else first free slot, else round-robin victim
  function automatic void absorb_route(input logic [31:0] key, input logic [31:0] gw);
    int slot;
    slot = find_route(key);
    if (slot < 0) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!route_live[i]) begin
          slot = i;
          break;
        end
      end
    end
    if (slot < 0) begin
      slot   = victim;
      victim = (victim + 1) % TABLE_ENTRIES;
    end
    route_key[slot]  = key;
    route_gw[slot]   = gw;
    route_live[slot] = 1'b1;
  endfunction

  function automatic logic [15:0] outer_checksum(input logic [15:0] len, input logic [15:0] id,
                                                 input logic [31:0] src, input logic [31:0] dst);
    logic [31:0] acc;
    acc = 32'(VER_IHL_TOS) + 32'(len) + 32'(id) + 32'({OUTER_TTL, OUTER_PROTO})
        + 32'(src[31:16]) + 32'(src[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0]);
    acc = 32'(acc[15:0]) + (acc >> 16);
    acc = 32'(acc[15:0]) + (acc >> 16);
    return ~acc[15:0];
  endfunction

  function automatic decision_t decide_request();
    decision_t d;
    int        slot;
    d = '0;
    if (req.kind == PKT_TUNNELLED) begin
      absorb_route(req.inner_source, req.outer_source);
      d.act   = ACT_DECAP;
      d.strip = req.outer_header_bytes;
    end else begin
      slot = find_route(req.destination);
      if (slot < 0) begin
        d.act = ACT_DROP;
      end else begin
        d.act       = ACT_ENCAP;
        d.gateway   = route_gw[slot];
        d.total_len = req.packet_length + OUTER_HDR_LEN;
        d.ident     = next_ident;
        d.csum      = outer_checksum(d.total_len, d.ident, tunnel_src, d.gateway);
        next_ident  = next_ident + 16'd1;
      end
    end
    return d;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decision_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) route_live[i] = 1'b0;
      victim     = 0;
      next_ident = '0;
      tunnel_src = '0;
      errors     = 0;
      expected_decisions.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we_i) tunnel_src = cfg_wdata_i;
      // results first, so a stray result never meets a request taken this edge
      if (res.valid && res.ready) begin
        if (expected_decisions.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, got action %0d",
                   $time, res.action);
          errors++;
        end else begin
          want = expected_decisions.pop_front();
          check_field("action", 32'(want.act), 32'(res.action));
          check_field("strip_bytes", 32'(want.strip), 32'(res.strip_bytes));
          check_field("outer_destination", want.gateway, res.outer_destination);
          check_field("total_length", 32'(want.total_len), 32'(res.total_length));
          check_field("identification", 32'(want.ident), 32'(res.identification));
          check_field("header_checksum", 32'(want.csum), 32'(res.header_checksum));
        end
      end
      if (req.valid && req.ready) expected_decisions.push_back(decide_request());
      mismatches  <= errors;
      outstanding <= expected_decisions.size();
    end
  end

endmodule

// ----- sim/ipip_tunnel_gateway_mapper_tb.sv -----
// testbench top of the ip-in-ip tunnel gateway mapper: stimulus and verdict
module ipip_tunnel_gateway_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipgw_pkg::*;
  import ipgw_tb_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  // bound on waiting for the last outstanding results of a phase
  localparam int SETTLE_LIMIT  = 20000;
  // quiet time after the last result, above the worst table walk
  localparam int DRAIN_CYCLES  = 120;
  // encapsulations in the run of repeated hits on the first entry
  localparam int ID_RUN        = 40;
  localparam int FILL_LEARNS   = 140;
  localparam int MIXED_ITEMS   = 440;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  ipgw_req_if req_ch ();
  ipgw_res_if res_ch ();

  int unsigned mismatches;
  int unsigned outstanding;

  // keys taught so far, newest last; old ones may have been evicted since
  logic [31:0] taught_keys[$];

  always #4 clk_i = ~clk_i;

  ipip_tunnel_gateway_mapper #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  ipgw_route_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) route_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // one request on the channel after a randomly drawn pause, possibly none; returns at acceptance
  task automatic put_request(input pkt_kind_e kind, input logic [31:0] osrc,
                             input logic [31:0] isrc, input logic [31:0] dst,
                             input logic [5:0] ohb, input logic [15:0] plen);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid              <= 1'b1;
    req_ch.kind               <= kind;
    req_ch.outer_source       <= osrc;
    req_ch.inner_source       <= isrc;
    req_ch.destination        <= dst;
    req_ch.outer_header_bytes <= ohb;
    req_ch.packet_length      <= plen;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
  endtask

  // tunnelled packet: key is the inner source, reached via the outer source;
  // the unused fields carry noise that the block has to ignore
  task automatic learn_route(input logic [31:0] key, input logic [31:0] gw,
                             input logic [5:0] ohb);
    put_request(PKT_TUNNELLED, gw, key, $urandom(), ohb, 16'($urandom()));
    taught_keys.push_back(key);
  endtask

  task automatic send_packet(input logic [31:0] dst, input logic [15:0] plen);
    put_request(PKT_PLAIN, $urandom(), $urandom(), dst, 6'($urandom()), plen);
  endtask

  // strip length: mostly legal header sizes, sometimes any 6-bit value
  function automatic logic [5:0] pick_strip();
    return ($urandom_range(0, 4) != 0) ? 6'($urandom_range(20, 60))
                                       : 6'($urandom_range(0, 63));
  endfunction

  // packet length: mostly legal, some tiny, some past the wrap point
  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 40));
      1:       return 16'($urandom_range(65500, 65535));
      default: return 16'($urandom_range(0, 65515));
    endcase
  endfunction

  // a destination biased toward recently taught keys
  function automatic logic [31:0] pick_known();
    int depth;
    depth = taught_keys.size() - 1;
    if (depth > 90) depth = 90;
    return taught_keys[taught_keys.size() - 1 - $urandom_range(0, depth)];
  endfunction

  // wait until every request has its result, then a little longer
  task automatic settle();
    int waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // register write, only issued while the mapper is idle
  task automatic set_tunnel_source(input logic [31:0] addr);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // result side: a randomly drawn ready pause, possibly none, before every result
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, 9);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (res_ch.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int          r;
    logic [31:0] k1, k2, k3;

    // every input known from the start
    rst_ni                    <= 1'b0;
    cfg_we_i                  <= 1'b0;
    cfg_wdata_i               <= '0;
    req_ch.valid              <= 1'b0;
    req_ch.kind               <= PKT_TUNNELLED;
    req_ch.outer_source       <= '0;
    req_ch.inner_source       <= '0;
    req_ch.destination        <= '0;
    req_ch.outer_header_bytes <= '0;
    req_ch.packet_length      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    set_tunnel_source(32'hC0A8_0001);
    // empty table: any lookup misses and is dropped
    send_packet($urandom(), 16'd100);
    // all-zero key to all-ones gateway, shortest legal outer header
    learn_route(32'h0000_0000, 32'hFFFF_FFFF, 6'd20);
    send_packet(32'h0000_0000, 16'd0);
    // all-ones key to all-zero gateway, longest legal outer header
    learn_route(32'hFFFF_FFFF, 32'h0000_0000, 6'd60);
    // largest length that fits, then lengths whose total wraps
    send_packet(32'hFFFF_FFFF, 16'd65515);
    send_packet(32'hFFFF_FFFF, 16'd65535);
    // key already present: gateway replaced where it stands
    learn_route(32'h0000_0000, 32'hC000_0201, 6'd0);
    send_packet(32'h0000_0000, 16'd65516);
    // strip lengths outside the legal header range pass through
    k1 = $urandom();
    k2 = $urandom();
    k3 = $urandom();
    learn_route(k1, $urandom(), 6'd63);
    learn_route(k2, $urandom(), 6'd19);
    learn_route(k3, $urandom(), 6'd61);
    send_packet(k1, 16'd1500);
    send_packet(k2, 16'd40);
    send_packet(k3, 16'd576);
    // unknown destination with a table that has entries
    send_packet(32'h7FFF_FFFF, 16'd64);
    send_packet(32'h8000_0000, 16'd64);
    settle();

    // ---- repeated hits on the first entry, all-ones source ----
    set_tunnel_source(32'hFFFF_FFFF);
    for (int n = 0; n < ID_RUN; n++) send_packet(32'h0000_0000, pick_length());
    settle();

    // ---- fill the table, then force round-robin replacement past the wrap ----
    set_tunnel_source(32'h0000_0000);
    for (int n = 0; n < FILL_LEARNS; n++) begin
      learn_route($urandom(), $urandom(), pick_strip());
      if ($urandom_range(0, 1) == 0) send_packet(pick_known(), pick_length());
    end
    settle();

    // ---- mixed traffic: mostly learn-then-forward, some noise ----
    set_tunnel_source($urandom());
    for (int n = 0; n < MIXED_ITEMS; n++) begin
      if (n == MIXED_ITEMS / 2) begin
        settle();
        set_tunnel_source($urandom());
      end
      r = $urandom_range(0, 99);
      if (r < 55)      send_packet(pick_known(), pick_length());
      else if (r < 65) send_packet($urandom(), pick_length());
      else if (r < 80) learn_route(pick_known(), $urandom(), pick_strip());
      else             learn_route($urandom(), $urandom(), pick_strip());
    end

    // ---- wrap up ----
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (outstanding != 0)
      $display("%0t: %0d results never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #80ms;
    $display("simulation failed");
    $finish;
  end

endmodule
